// ----- rtl/rsc_pkg.sv -----
// ============================================================================
// rsc_pkg: shared types and constants of the RPN stack calculator
// Character codes, fixed-point format, command beat carried from the
// parser front end to the stack engine, and digit helper functions.
// ============================================================================
package rsc_pkg;

    // Fixed-point format: signed Q(INT_BITS).FRAC_BITS
    localparam int FRAC_BITS       = 32;
    localparam int INT_BITS        = 64 - FRAC_BITS;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int IACC_W          = INT_BITS + 1;
    localparam int FCNT_W          = 4;
    localparam int Q_DEPTH         = 4;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Error flag bit positions
    localparam int FLAG_UNDER   = 0;
    localparam int FLAG_OVER    = 1;
    localparam int FLAG_DIV0    = 2;
    localparam int FLAG_UNKNOWN = 3;

    // Saturation cap of the integer accumulator
    localparam logic [IACC_W-1:0] INT_CAP = {1'b1, {INT_BITS{1'b0}}};

    // Powers of ten for the fraction digit count
    function automatic logic [63:0] pow10(input logic [FCNT_W-1:0] n);
        logic [63:0] t;
        logic [63:0] p;
        t = 64'd1;
        p = 64'd1;
        for (int i = 1; i <= 12; i++)
        begin
            t = t * 64'd10;
            if (n == FCNT_W'(i))
                p = t;
        end
        return p;
    endfunction

    localparam int FACC_W = $clog2(pow10(FCNT_W'(MAX_FRAC_DIGITS)));

    typedef enum logic [1:0] {
        CMD_NUM   = 2'd0,
        CMD_OP    = 2'd1,
        CMD_EMIT  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [7:0]          op;
        logic [IACC_W-1:0]   iacc;
        logic [FACC_W-1:0]   facc;
        logic [FCNT_W-1:0]   fcnt;
        logic                neg;
        logic                lead_ok;
    } cmd_t;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    // acc * 10 + digit, saturating at INT_CAP
    function automatic logic [IACC_W-1:0] int_step(input logic [IACC_W-1:0] acc,
                                                    input logic [7:0] ch);
        logic [IACC_W+3:0] e;
        logic [IACC_W+3:0] w;
        e = {4'b0000, acc};
        w = (e << 3) + (e << 1) + {{IACC_W{1'b0}}, ch[3:0]};
        if (w > {4'b0000, INT_CAP})
            return INT_CAP;
        return w[IACC_W-1:0];
    endfunction

    // acc * 10 + digit for the fraction digits
    function automatic logic [FACC_W-1:0] frac_step(input logic [FACC_W-1:0] acc,
                                                     input logic [7:0] ch);
        logic [FACC_W+3:0] e;
        logic [FACC_W+3:0] w;
        e = {4'b0000, acc};
        w = (e << 3) + (e << 1) + {{FACC_W{1'b0}}, ch[3:0]};
        return w[FACC_W-1:0];
    endfunction

endpackage

// ----- rtl/rsc_front.sv -----
// ============================================================================
// rsc_front: character parser
// Tokenises the byte stream, accumulates number digits and issues number,
// operator, emit and reset commands to the command queue.
// ============================================================================
module rsc_front
    import rsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       q_wr,
    output cmd_t       q_wdata,
    input  logic       q_full
);

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_LEAD    = 6'b000010,
        M_INT     = 6'b000100,
        M_FRAC    = 6'b001000,
        M_DOTFRAC = 6'b010000,
        M_DISCARD = 6'b100000
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [7:0]          pend_reg, pend_next;
    logic [IACC_W-1:0]   iacc_reg, iacc_next;
    logic [FACC_W-1:0]   facc_reg, facc_next;
    logic [FCNT_W-1:0]   fcnt_reg, fcnt_next;
    logic                neg_reg, neg_next;
    logic                hold_reg, hold_next;

    logic  accept;
    logic  is_dig;
    logic  do_idle;
    logic  c1_valid;
    logic  emit;
    cmd_t  c1;
    cmd_t  emit_cmd;
    cmd_t  num_cmd;

    assign in_ready = !hold_reg && !q_full;
    assign accept   = in_valid && in_ready;
    assign is_dig   = is_digit(in_char);

    // Command templates
    always_comb
    begin
        emit_cmd         = '0;
        emit_cmd.kind    = CMD_EMIT;
        num_cmd          = '0;
        num_cmd.kind     = CMD_NUM;
        num_cmd.iacc     = iacc_reg;
        num_cmd.facc     = facc_reg;
        num_cmd.fcnt     = fcnt_reg;
        num_cmd.neg      = neg_reg;
        num_cmd.lead_ok  = is_digit(pend_reg) || (pend_reg == CH_PLUS) ||
                           (pend_reg == CH_MINUS) || (pend_reg == CH_DOT);
    end

    // Token state machine
    always_comb
    begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        iacc_next = iacc_reg;
        facc_next = facc_reg;
        fcnt_next = fcnt_reg;
        neg_next  = neg_reg;
        do_idle   = 1'b0;
        c1_valid  = 1'b0;
        c1        = num_cmd;
        emit      = 1'b0;

        unique case (mode_reg)
            M_LEAD:
            begin
                if (is_dig)
                begin
                    neg_next = (pend_reg == CH_MINUS);
                    if (pend_reg == CH_DOT)
                    begin
                        mode_next = M_DOTFRAC;
                        facc_next = frac_step('0, in_char);
                        fcnt_next = FCNT_W'(1);
                    end
                    else
                    begin
                        mode_next = M_INT;
                        iacc_next = int_step('0, in_char);
                    end
                end
                else
                begin
                    c1_valid = 1'b1;
                    c1       = '0;
                    c1.kind  = CMD_OP;
                    c1.op    = pend_reg;
                    do_idle  = 1'b1;
                end
            end
            M_INT:
            begin
                if (is_dig)
                    iacc_next = int_step(iacc_reg, in_char);
                else if (in_char == CH_DOT)
                    mode_next = M_FRAC;
                else
                begin
                    c1_valid = 1'b1;
                    do_idle  = 1'b1;
                end
            end
            M_FRAC, M_DOTFRAC:
            begin
                if (is_dig)
                begin
                    if (fcnt_reg < FCNT_W'(MAX_FRAC_DIGITS))
                    begin
                        facc_next = frac_step(facc_reg, in_char);
                        fcnt_next = fcnt_reg + FCNT_W'(1);
                    end
                end
                else if ((mode_reg == M_DOTFRAC) && (in_char == CH_DOT))
                    mode_next = M_DISCARD;
                else
                begin
                    c1_valid = 1'b1;
                    do_idle  = 1'b1;
                end
            end
            M_DISCARD:
            begin
                if (!is_dig)
                begin
                    c1_valid = 1'b1;
                    do_idle  = 1'b1;
                end
            end
            default:
                do_idle = 1'b1;
        endcase

        // Character seen with no token open
        if (do_idle)
        begin
            mode_next = M_IDLE;
            iacc_next = '0;
            facc_next = '0;
            fcnt_next = '0;
            neg_next  = 1'b0;
            if ((in_char == CH_SPACE) || (in_char == CH_TAB))
                mode_next = M_IDLE;
            else if (in_char == CH_NL)
                emit = 1'b1;
            else
            begin
                pend_next = in_char;
                if (is_dig)
                begin
                    mode_next = M_INT;
                    iacc_next = int_step('0, in_char);
                end
                else
                    mode_next = M_LEAD;
            end
        end

        // End of stream: back to reset state
        if (in_last)
        begin
            mode_next = M_IDLE;
            pend_next = '0;
            iacc_next = '0;
            facc_next = '0;
            fcnt_next = '0;
            neg_next  = 1'b0;
            c1_valid  = 1'b1;
            c1        = '0;
            c1.kind   = CMD_RESET;
            emit      = 1'b0;
        end
    end

    // Queue write: held emit first, else this beat's command
    always_comb
    begin
        hold_next = hold_reg;
        if (hold_reg)
        begin
            q_wr    = !q_full;
            q_wdata = emit_cmd;
            if (!q_full)
                hold_next = 1'b0;
        end
        else
        begin
            q_wr    = accept && (c1_valid || emit);
            q_wdata = c1_valid ? c1 : emit_cmd;
            if (accept && c1_valid && emit)
                hold_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pend_reg <= '0;
            iacc_reg <= '0;
            facc_reg <= '0;
            fcnt_reg <= '0;
            neg_reg  <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                pend_reg <= pend_next;
                iacc_reg <= iacc_next;
                facc_reg <= facc_next;
                fcnt_reg <= fcnt_next;
                neg_reg  <= neg_next;
            end
        end
    end

endmodule

// ----- rtl/rsc_cmd_queue.sv -----
// ============================================================================
// rsc_cmd_queue: command queue
// Small register FIFO between the parser and the stack engine.
// ============================================================================
module rsc_cmd_queue
    import rsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    localparam int QAW = $clog2(Q_DEPTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);

    cmd_t           entry_reg [Q_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign full    = (count_reg == QCW'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = wr_ptr_reg + QAW'(1);
        if (rd_en)
            rd_ptr_next = rd_ptr_reg + QAW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + QCW'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - QCW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("command queue written while full");
    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("command queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(Q_DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

// ----- rtl/rsc_back.sv -----
// ============================================================================
// rsc_back: stack engine
// Executes queued commands on the value stack: number conversion, the five
// arithmetic operators with a shared iterative divider and a sequenced
// multiplier, and result emission through an output register.
// ============================================================================
module rsc_back
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    output logic        q_rd,
    input  cmd_t        q_rdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_value,
    output logic [3:0]  out_flags
);

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int DV_W = 64 + FRAC_BITS;
    localparam int IT_W = $clog2(DV_W + 1);
    localparam logic [63:0] S_MIN = {1'b1, 63'd0};
    localparam logic [63:0] S_MAX = {1'b0, {63{1'b1}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_XB    = 7'b0000010,
        S_YB    = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_EMITB = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        K_CONV = 2'd0,
        K_DIV  = 2'd1,
        K_MOD  = 2'd2,
        K_MUL  = 2'd3
    } work_t;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] to_sat(input logic [63:0] m, input logic ovf,
                                           input logic neg);
        if (neg)
            return (ovf || (m > S_MIN)) ? S_MIN : (64'd0 - m);
        return (ovf || m[63]) ? S_MAX : m;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
            return a[63] ? S_MIN : S_MAX;
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if ((a[63] != b[63]) && (s[63] != a[63]))
            return a[63] ? S_MIN : S_MAX;
        return s;
    endfunction

    // Control state
    state_t         state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [3:0]     flags_reg, flags_next;
    logic           pop_ok_reg, pop_ok_next;
    logic [IT_W-1:0] it_reg, it_next;
    logic [2:0]     mstep_reg, mstep_next;
    logic           oval_reg, oval_next;

    // Payload
    logic [63:0]        x_reg, x_next;
    logic [7:0]         op_reg, op_next;
    logic [IACC_W-1:0]  iacc_reg, iacc_next;
    logic               lead_ok_reg, lead_ok_next;
    logic               neg_reg, neg_next;
    work_t              kind_reg, kind_next;
    logic [64:0]        r_reg, r_next;
    logic [63:0]        d_reg, d_next;
    logic [DV_W-1:0]    dv_reg, dv_next;
    logic [63:0]        q_reg, q_next;
    logic               ovf_reg, ovf_next;
    logic [63:0]        ma_reg, ma_next;
    logic [63:0]        mb_reg, mb_next;
    logic [63:0]        prod_reg, prod_next;
    logic [127:0]       acc_reg, acc_next;
    logic [63:0]        oval_data_reg;
    logic [3:0]         oflag_data_reg;
    logic [63:0]        rdata_reg;

    // Stack memory
    logic [63:0]    stack_mem [STACK_DEPTH];
    logic [SPW-1:0] sp_dec;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    logic        pop_req, push_req, push_we, rd_en, out_load;
    logic [63:0] push_val;
    logic [63:0] rd_val;
    logic [63:0] ux, uy;
    logic [64:0] r_sh, r_sub;
    logic        ge;
    logic [31:0] m_opa, m_opb;
    logic [127:0] term;

    assign sp_dec   = sp_reg - SPW'(1);
    assign rd_addr  = sp_dec[AW-1:0];
    assign wr_addr  = sp_reg[AW-1:0];
    assign rd_val   = pop_ok_reg ? rdata_reg : 64'd0;
    assign ux       = mag(x_reg);
    assign uy       = mag(rd_val);

    assign out_valid = oval_reg;
    assign out_value = oval_data_reg;
    assign out_flags = oflag_data_reg;

    // Divider step: one quotient bit per cycle
    assign r_sh  = {r_reg[63:0], dv_reg[DV_W-1]};
    assign r_sub = r_sh - {1'b0, d_reg};
    assign ge    = (r_sh >= {1'b0, d_reg});

    // Multiplier operand select, one 32x32 partial product per step
    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin m_opa = ma_reg[31:0];  m_opb = mb_reg[31:0];  end
            3'd1:    begin m_opa = ma_reg[31:0];  m_opb = mb_reg[63:32]; end
            3'd2:    begin m_opa = ma_reg[63:32]; m_opb = mb_reg[31:0];  end
            default: begin m_opa = ma_reg[63:32]; m_opb = mb_reg[63:32]; end
        endcase
        case (mstep_reg)
            3'd1:    term = {64'd0, prod_reg};
            3'd2:    term = {32'd0, prod_reg, 32'd0};
            3'd3:    term = {32'd0, prod_reg, 32'd0};
            3'd4:    term = {prod_reg, 64'd0};
            default: term = '0;
        endcase
    end

    // Command sequencer
    always_comb
    begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        flags_next   = flags_reg;
        pop_ok_next  = pop_ok_reg;
        it_next      = it_reg;
        mstep_next   = mstep_reg;
        oval_next    = oval_reg && !out_ready;
        x_next       = x_reg;
        op_next      = op_reg;
        iacc_next    = iacc_reg;
        lead_ok_next = lead_ok_reg;
        neg_next     = neg_reg;
        kind_next    = kind_reg;
        r_next       = r_reg;
        d_next       = d_reg;
        dv_next      = dv_reg;
        q_next       = q_reg;
        ovf_next     = ovf_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        q_rd         = 1'b0;
        pop_req      = 1'b0;
        push_req     = 1'b0;
        push_val     = 64'd0;
        out_load     = 1'b0;

        unique case (state_reg)
            S_XB:
            begin
                x_next = rd_val;
                if ((op_reg == CH_SLASH) && (rd_val == 64'd0))
                begin
                    flags_next[FLAG_DIV0] = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    pop_req    = 1'b1;
                    state_next = S_YB;
                end
            end
            S_YB:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    CH_PLUS:
                    begin
                        push_req = 1'b1;
                        push_val = sat_add(rd_val, x_reg);
                    end
                    CH_MINUS:
                    begin
                        push_req = 1'b1;
                        push_val = sat_sub(rd_val, x_reg);
                    end
                    CH_STAR:
                    begin
                        ma_next    = uy;
                        mb_next    = ux;
                        acc_next   = '0;
                        mstep_next = 3'd0;
                        neg_next   = x_reg[63] ^ rd_val[63];
                        kind_next  = K_MUL;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        if ((op_reg != CH_SLASH) && (x_reg == 64'd0))
                        begin
                            flags_next[FLAG_DIV0] = 1'b1;
                            push_req = 1'b1;
                        end
                        else
                        begin
                            r_next     = '0;
                            d_next     = ux;
                            dv_next    = {uy, {FRAC_BITS{1'b0}}};
                            q_next     = '0;
                            ovf_next   = 1'b0;
                            state_next = S_DIV;
                            if (op_reg == CH_SLASH)
                            begin
                                it_next   = IT_W'(DV_W);
                                neg_next  = x_reg[63] ^ rd_val[63];
                                kind_next = K_DIV;
                            end
                            else
                            begin
                                it_next   = IT_W'(64);
                                neg_next  = rd_val[63];
                                kind_next = K_MOD;
                            end
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                r_next   = ge ? r_sub : r_sh;
                q_next   = {q_reg[62:0], ge};
                ovf_next = ovf_reg | q_reg[63];
                dv_next  = {dv_reg[DV_W-2:0], 1'b0};
                it_next  = it_reg - IT_W'(1);
                if (it_reg == IT_W'(1))
                    state_next = S_DONE;
            end
            S_MUL:
            begin
                prod_next  = m_opa * m_opb;
                acc_next   = acc_reg + term;
                mstep_next = mstep_reg + 3'd1;
                if (mstep_reg == 3'd4)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                push_req   = 1'b1;
                state_next = S_IDLE;
                case (kind_reg)
                    K_CONV:
                        push_val = lead_ok_reg ?
                            to_sat({iacc_reg[INT_BITS-1:0], q_reg[FRAC_BITS-1:0]},
                                   iacc_reg[INT_BITS], neg_reg) : 64'd0;
                    K_DIV:
                        push_val = to_sat(q_reg, ovf_reg, neg_reg);
                    K_MOD:
                        push_val = neg_reg ? (64'd0 - r_reg[63:0]) : r_reg[63:0];
                    default:
                        push_val = to_sat(acc_reg[FRAC_BITS+63:FRAC_BITS],
                                          |acc_reg[127:FRAC_BITS+64], neg_reg);
                endcase
            end
            S_EMITB:
            begin
                if (!oval_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    oval_next  = 1'b1;
                    flags_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                if (!q_empty)
                begin
                    q_rd = 1'b1;
                    unique case (q_rdata.kind)
                        CMD_RESET:
                        begin
                            sp_next    = '0;
                            flags_next = '0;
                        end
                        CMD_NUM:
                        begin
                            r_next       = {{(65-FACC_W){1'b0}}, q_rdata.facc};
                            d_next       = pow10(q_rdata.fcnt);
                            dv_next      = '0;
                            q_next       = '0;
                            ovf_next     = 1'b0;
                            it_next      = IT_W'(FRAC_BITS);
                            iacc_next    = q_rdata.iacc;
                            lead_ok_next = q_rdata.lead_ok;
                            neg_next     = q_rdata.neg;
                            kind_next    = K_CONV;
                            state_next   = S_DIV;
                        end
                        CMD_EMIT:
                        begin
                            pop_req    = 1'b1;
                            state_next = S_EMITB;
                        end
                        default:
                        begin
                            unique case (q_rdata.op) inside
                                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT:
                                begin
                                    op_next    = q_rdata.op;
                                    pop_req    = 1'b1;
                                    state_next = S_XB;
                                end
                                default:
                                    flags_next[FLAG_UNKNOWN] = 1'b1;
                            endcase
                        end
                    endcase
                end
            end
        endcase

        // Stack pointer: at most one pop or push per cycle
        rd_en   = 1'b0;
        push_we = 1'b0;
        if (pop_req)
        begin
            if (sp_reg != '0)
            begin
                sp_next     = sp_dec;
                rd_en       = 1'b1;
                pop_ok_next = 1'b1;
            end
            else
            begin
                pop_ok_next = 1'b0;
                flags_next[FLAG_UNDER] = 1'b1;
            end
        end
        if (push_req)
        begin
            if (sp_reg < SPW'(STACK_DEPTH))
            begin
                push_we = 1'b1;
                sp_next = sp_reg + SPW'(1);
            end
            else
                flags_next[FLAG_OVER] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sp_reg     <= '0;
            flags_reg  <= '0;
            pop_ok_reg <= 1'b0;
            it_reg     <= '0;
            mstep_reg  <= '0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            flags_reg  <= flags_next;
            pop_ok_reg <= pop_ok_next;
            it_reg     <= it_next;
            mstep_reg  <= mstep_next;
            oval_reg   <= oval_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        op_reg      <= op_next;
        iacc_reg    <= iacc_next;
        lead_ok_reg <= lead_ok_next;
        neg_reg     <= neg_next;
        kind_reg    <= kind_next;
        r_reg       <= r_next;
        d_reg       <= d_next;
        dv_reg      <= dv_next;
        q_reg       <= q_next;
        ovf_reg     <= ovf_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        if (out_load)
        begin
            oval_data_reg  <= rd_val;
            oflag_data_reg <= flags_reg;
        end
    end

    // Stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (push_we)
            stack_mem[wr_addr] <= push_val;
        if (rd_en)
            rdata_reg <= stack_mem[rd_addr];
    end

endmodule

// ----- rtl/rpn_stack_calculator.sv -----
// Timing: the parser takes a character whenever the queue has room and no emit
// is held; a result is loaded into the output register after its newline once
// queued commands ahead of it are done. The stack engine starts a command only
// when through with the last; numbers, / and % use the divider, * the multiplier;
// spaces and digits inside a token cost no engine time.
// Reset: asynchronous, active low; clears parser, queue, stack pointer and flags.
// ============================================================================
// rpn_stack_calculator: reverse-Polish calculator, one ASCII byte per beat
// Parser front end, command queue and stack engine on Q32.32 values.
// ============================================================================
module rpn_stack_calculator
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value
    output logic [3:0]  m_axis_tuser    // [0] stack_underflow, [1] stack_overflow,
                                        // [2] divide_by_zero, [3] unknown_command
);

    logic q_wr;
    logic q_full;
    logic q_rd;
    logic q_empty;
    cmd_t q_wdata;
    cmd_t q_rdata;

    rsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata),
        .q_full   (q_full)
    );

    rsc_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    rsc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .q_rdata   (q_rdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_flags (m_axis_tuser)
    );

endmodule
